FILE: src/mpf_pkg.sv
// shared constants, types and helpers of the multilevel priority fifo
`timescale 1ns / 1ps

package mpf_pkg;

  localparam int MAX_PRIO    = 5;
  localparam int NUM_LEVELS  = MAX_PRIO + 1;
  localparam int LEVEL_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;

  localparam int PRIO_W = 3;
  localparam int TOP_W  = 4;
  localparam int STAT_W = 2;
  localparam int IDX_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(ENTRIES);

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PRIO = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic signed [TOP_W-1:0] TOP_NONE = -4'sd1;

  typedef logic [NUM_LEVELS-1:0] level_mask_t;

  typedef struct packed {
    logic                     wr;
    logic                     rd;
    logic [ADDR_W-1:0]        addr;
    logic [STAT_W-1:0]        status;
    logic                     hit;
    logic signed [TOP_W-1:0]  top;
  } mpf_cmd_t;

  function automatic logic signed [TOP_W-1:0] top_of(input level_mask_t bits);
    logic signed [TOP_W-1:0] r;
    r = TOP_NONE;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (bits[l]) r = TOP_W'(l);
    end
    return r;
  endfunction

endpackage

FILE: src/mpf_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface mpf_req_if import mpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [PRIO_W-1:0]    priority_req;
  logic [TAG_WIDTH-1:0] item_tag;

  modport source(output valid, op, priority_req, item_tag, input ready);
  modport sink(input valid, op, priority_req, item_tag, output ready);
endinterface

interface mpf_rsp_if import mpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     pop_valid;
  logic [TAG_WIDTH-1:0]     popped_tag;
  logic [STAT_W-1:0]        status;
  logic signed [TOP_W-1:0]  top_priority;

  modport source(output valid, pop_valid, popped_tag, status, top_priority, input ready);
  modport sink(input valid, pop_valid, popped_tag, status, top_priority, output ready);
endinterface

FILE: src/mpf_entry_ram.sv
// single-port-write, registered-read entry memory
`timescale 1ns / 1ps

module mpf_entry_ram #(
  parameter int DEPTH = 96,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mpf_level_ctrl.sv
// per-level head, tail and count registers and the push/pop decision
`timescale 1ns / 1ps

module mpf_level_ctrl import mpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              op,
  input  logic [PRIO_W-1:0] priority_req,
  output mpf_cmd_t          cmd
);

  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(LEVEL_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(LEVEL_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_I  = IDX_W'(LEVEL_DEPTH - 1);

  logic [IDX_W-1:0] head  [NUM_LEVELS];
  logic [IDX_W-1:0] tail  [NUM_LEVELS];
  logic [CNT_W-1:0] count [NUM_LEVELS];

  level_mask_t             busy_lvls;
  level_mask_t             busy_next;
  logic signed [TOP_W-1:0] top_now;
  logic                    prio_ok;
  logic [PRIO_W-1:0]       sel;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_next;
  logic                    do_push;
  logic                    do_pop;

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      busy_lvls[l] = (count[l] != '0);
    end
  end

  assign top_now = top_of(busy_lvls);
  assign prio_ok = (priority_req <= PRIO_W'(MAX_PRIO));

  always_comb begin
    sel      = '0;
    idx      = '0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    busy_next = busy_lvls;
    cmd      = '0;
    if (op) begin
      if (top_now == TOP_NONE) begin
        cmd.status = ST_EMPTY;
      end else begin
        sel        = top_now[PRIO_W-1:0];
        idx        = head[sel];
        do_pop     = 1'b1;
        cmd.status = ST_OK;
        if (count[sel] == CNT_W'(1)) busy_next[sel] = 1'b0;
      end
    end else begin
      if (!prio_ok) begin
        cmd.status = ST_BAD_PRIO;
      end else begin
        sel = priority_req;
        idx = tail[sel];
        if (count[sel] == FULL_C) begin
          cmd.status = ST_FULL;
        end else begin
          do_push        = 1'b1;
          cmd.status     = ST_OK;
          busy_next[sel] = 1'b1;
        end
      end
    end
    cmd.wr   = do_push;
    cmd.rd   = do_pop;
    cmd.hit  = do_pop;
    cmd.addr = ADDR_W'(sel) * DEPTH_A + ADDR_W'(idx);
    cmd.top  = top_of(busy_next);
  end

  assign idx_next = (idx == LAST_I) ? '0 : idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
    end else if (accept) begin
      if (do_push) begin
        tail[sel]  <= idx_next;
        count[sel] <= count[sel] + CNT_W'(1);
      end else if (do_pop) begin
        head[sel]  <= idx_next;
        count[sel] <= count[sel] - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/multilevel_priority_fifo.sv
// Multilevel priority fifo: one fifo per priority level 0..MAX_PRIO, pop from the highest
// non-empty level. The accept cycle decides and updates the level pointers and issues the
// entry memory write or read; once the response register has room, the registered read
// data is collected into that register. The request side is ready again once the
// response register has room, so a stalled response holds up one request at most.
// Entries are never cleared; a pop only ever reads slots that a push has written.
`timescale 1ns / 1ps

module multilevel_priority_fifo import mpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mpf_req_if.sink   req,
  mpf_rsp_if.source rsp
);

  mpf_cmd_t                cmd;
  logic                    accept;
  logic                    busy;
  logic                    load;
  logic                    pend_hit;
  logic [STAT_W-1:0]       pend_status;
  logic signed [TOP_W-1:0] pend_top;
  logic [TAG_WIDTH-1:0]    rd_data;
  logic                    out_valid;
  logic                    out_hit;
  logic [TAG_WIDTH-1:0]    out_tag;
  logic [STAT_W-1:0]       out_status;
  logic signed [TOP_W-1:0] out_top;

  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;
  assign load      = busy && (!out_valid || rsp.ready);

  mpf_level_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (req.op),
    .priority_req (req.priority_req),
    .cmd          (cmd)
  );

  mpf_entry_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (TAG_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && cmd.wr),
    .waddr (cmd.addr),
    .wdata (req.item_tag),
    .re    (accept && cmd.rd),
    .raddr (cmd.addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_hit    <= cmd.hit;
      pend_status <= cmd.status;
      pend_top    <= cmd.top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hit    <= pend_hit;
      out_tag    <= pend_hit ? rd_data : '0;
      out_status <= pend_status;
      out_top    <= pend_top;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.pop_valid    = out_hit;
  assign rsp.popped_tag   = out_tag;
  assign rsp.status       = out_status;
  assign rsp.top_priority = out_top;

endmodule

FILE: src/mpf_checker.sv
// port-level assertions for the multilevel priority fifo
`timescale 1ns / 1ps

module mpf_checker import mpf_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    pop_valid,
  input logic [TAG_WIDTH-1:0]    popped_tag,
  input logic [STAT_W-1:0]       status,
  input logic [TOP_W-1:0]        top_priority
);

  // a word waiting on the response side stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_tag) && $stable(status))
    else $error("response dropped or changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous still in flight");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> !pop_valid && (popped_tag == '0)
      && (top_priority == TOP_W'(TOP_NONE)))
    else $error("empty pop carries data or a level");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && pop_valid |-> (status == ST_OK))
    else $error("popped word with error status");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (top_priority <= TOP_W'(MAX_PRIO)) || (top_priority == TOP_W'(TOP_NONE)))
    else $error("top priority out of range");

endmodule

bind multilevel_priority_fifo mpf_checker u_mpf_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .pop_valid    (rsp.pop_valid),
  .popped_tag   (rsp.popped_tag),
  .status       (rsp.status),
  .top_priority (rsp.top_priority)
);

FILE: bench/tb.sv
// self-checking testbench of the multilevel priority fifo with its own level queue tracker
`timescale 1ns / 1ps

module tb;
  import mpf_pkg::*;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_AFTER   = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                    pop_valid;
    logic [TAG_WIDTH-1:0]    popped_tag;
    logic [STAT_W-1:0]       status;
    logic signed [TOP_W-1:0] top_priority;
  } mpf_result_t;

  class level_queue_tracker;
    logic [TAG_WIDTH-1:0] slots [NUM_LEVELS][LEVEL_DEPTH];
    int unsigned head [NUM_LEVELS];
    int unsigned tail [NUM_LEVELS];
    int unsigned fill [NUM_LEVELS];
    mpf_result_t expected_responses [$];
    int fails;
    int stored, popped, bad_prio, full_drops, empty_pops;

    function void clear();
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] = 0;
        tail[l] = 0;
        fill[l] = 0;
      end
      expected_responses.delete();
      fails = 0;
      stored = 0;
      popped = 0;
      bad_prio = 0;
      full_drops = 0;
      empty_pops = 0;
    endfunction

    function logic signed [TOP_W-1:0] highest_level();
      for (int l = MAX_PRIO; l >= 0; l--) begin
        if (fill[l] != 0) return TOP_W'(l);
      end
      return TOP_NONE;
    endfunction

    function void note_request(logic op, logic [PRIO_W-1:0] prio, logic [TAG_WIDTH-1:0] tag);
      mpf_result_t r;
      int lv;
      r = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
        lv = int'(prio);
        if (lv > MAX_PRIO) begin
          r.status = ST_BAD_PRIO;
          bad_prio++;
        end else if (fill[lv] >= LEVEL_DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          slots[lv][tail[lv]] = tag;
          tail[lv] = (tail[lv] + 1 >= LEVEL_DEPTH) ? 0 : tail[lv] + 1;
          fill[lv]++;
          stored++;
        end
      end else begin
        lv = int'(highest_level());
        if (lv < 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          r.pop_valid = 1'b1;
          r.popped_tag = slots[lv][head[lv]];
          head[lv] = (head[lv] + 1 >= LEVEL_DEPTH) ? 0 : head[lv] + 1;
          fill[lv]--;
          popped++;
        end
      end
      r.top_priority = highest_level();
      expected_responses.push_back(r);
    endfunction

    function void check_response(mpf_result_t got);
      mpf_result_t want;
      if (expected_responses.size() == 0) begin
        $error("response word with nothing expected: status %0d", got.status);
        fails++;
        return;
      end
      want = expected_responses.pop_front();
      if (got.pop_valid !== want.pop_valid) begin
        $error("pop_valid: expected %0d, actual %0d", want.pop_valid, got.pop_valid);
        fails++;
      end
      if (got.popped_tag !== want.popped_tag) begin
        $error("popped_tag: expected %h, actual %h", want.popped_tag, got.popped_tag);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      if (got.top_priority !== want.top_priority) begin
        $error("top_priority: expected %0d, actual %0d", want.top_priority, got.top_priority);
        fails++;
      end
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mpf_req_if req_ch();
  mpf_rsp_if rsp_ch();

  multilevel_priority_fifo uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  level_queue_tracker tracker;
  int send_burst_left;
  bit send_idle_on;
  int recv_burst_left;
  bit recv_idle_on;
  int responses_seen;
  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int draw_gap(ref int burst_left, ref bit idle_on);
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 60);
      idle_on = ($urandom_range(0, 2) != 0);
    end
    burst_left--;
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic send_word(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [TAG_WIDTH-1:0] tag);
    int gap;
    gap = draw_gap(send_burst_left, send_idle_on);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.priority_req <= prio;
    req_ch.item_tag     <= tag;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, prio, tag);
  endtask

  task automatic run_receiver();
    int gap;
    mpf_result_t got;
    forever begin
      if (responses_seen == HOLD_AFTER) gap = HOLD_CYCLES;
      else gap = draw_gap(recv_burst_left, recv_idle_on);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.pop_valid    = rsp_ch.pop_valid;
      got.popped_tag   = rsp_ch.popped_tag;
      got.status       = rsp_ch.status;
      got.top_priority = rsp_ch.top_priority;
      tracker.check_response(got);
      responses_seen++;
    end
  endtask

  task automatic run_directed();
    send_word(OP_POP, 3'd7, 16'hFFFF);
    send_word(OP_PUSH, 3'd7, 16'hFFFF);
    send_word(OP_PUSH, PRIO_W'(MAX_PRIO + 1), 16'h0000);
    send_word(OP_PUSH, 3'd0, 16'h0000);
    send_word(OP_PUSH, PRIO_W'(MAX_PRIO), 16'hFFFF);
    send_word(OP_POP, 3'd0, 16'h0000);
    send_word(OP_POP, 3'd5, 16'hFFFF);
    send_word(OP_POP, 3'd2, 16'h5A5A);
    // fill one level past its depth
    for (int i = 0; i <= LEVEL_DEPTH; i++) begin
      send_word(OP_PUSH, 3'd2, TAG_WIDTH'($urandom));
    end
  endtask

  task automatic run_random(input int words);
    int left, phase_len, push_pct, fav, r;
    logic op;
    logic [PRIO_W-1:0] prio;
    left = words;
    while (left > 0) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: push_pct = 90;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      fav = $urandom_range(0, MAX_PRIO);
      for (int i = 0; i < phase_len && left > 0; i++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        r = $urandom_range(0, 99);
        if (op == OP_POP) prio = PRIO_W'($urandom);
        else if (r < 8) prio = PRIO_W'($urandom_range(MAX_PRIO + 1, 7));
        else if (r < 50) prio = PRIO_W'(fav);
        else prio = PRIO_W'($urandom_range(0, MAX_PRIO));
        send_word(op, prio, TAG_WIDTH'($urandom));
        left--;
      end
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    send_burst_left = 0;
    recv_burst_left = 0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    responses_seen = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_PUSH;
    req_ch.priority_req <= '0;
    req_ch.item_tag <= '0;
    rsp_ch.ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      run_receiver();
    join_none
    run_directed();
    run_random(RANDOM_WORDS);
    req_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d responses: %0d tags stored, %0d popped, %0d pops on empty",
             responses_seen, tracker.stored, tracker.popped, tracker.empty_pops);
    $display("rejected %0d pushes for priority and %0d for a full level, with a long output stall",
             tracker.bad_prio, tracker.full_drops);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mpf_pkg.sv
src/mpf_if.sv
src/mpf_entry_ram.sv
src/mpf_level_ctrl.sv
src/multilevel_priority_fifo.sv
src/mpf_checker.sv
bench/tb.sv
